@@ hw/rtl/ccfe_pkg.sv @@
package ccfe_pkg;

    localparam int FrameBytes = 9;
    localparam int IdxW       = $clog2(FrameBytes);

    // Frame bytes and characters
    localparam logic [7:0] StxByte   = 8'h02;
    localparam logic [7:0] EtxByte   = 8'h03;
    localparam logic [7:0] CharF     = 8'h46;  // 'F'
    localparam logic [7:0] CmdSet    = 8'h31;  // '1'
    localparam logic [7:0] CmdSwing  = 8'h35;  // '5'
    localparam logic [7:0] PowerOff  = 8'h30;  // '0'
    localparam logic [7:0] PowerOn   = 8'h31;  // '1'
    localparam logic [7:0] TempBase  = 8'h40;  // '@'
    localparam logic [7:0] FanAuto   = 8'h41;  // 'A'
    localparam logic [7:0] FanLow    = 8'h33;  // '3'
    localparam logic [7:0] FanMid    = 8'h34;  // '4'
    localparam logic [7:0] FanHigh   = 8'h35;  // '5'

    // Request kinds
    localparam logic ReqSettings = 1'b0;
    localparam logic ReqSwing    = 1'b1;

    // Input mode codes
    localparam logic [2:0] ModeOff  = 3'd0;
    localparam logic [2:0] ModeDry  = 3'd2;
    localparam logic [2:0] ModeCool = 3'd3;
    localparam logic [2:0] ModeHeat = 3'd4;
    localparam logic [2:0] ModeFan  = 3'd5;

    // Raw mode codes on the wire
    localparam logic [7:0] WireAuto = 8'd0;
    localparam logic [7:0] WireDry  = 8'd2;
    localparam logic [7:0] WireCool = 8'd3;
    localparam logic [7:0] WireHeat = 8'd4;
    localparam logic [7:0] WireFan  = 8'd6;

    // Input fan codes
    localparam logic [2:0] SpeedLow  = 3'd1;
    localparam logic [2:0] SpeedMid  = 3'd2;
    localparam logic [2:0] SpeedHigh = 3'd3;

    // Temperature range in tenths
    localparam logic signed [10:0] TempMin = 11'sd180;
    localparam logic signed [10:0] TempMax = 11'sd300;

    // Index of the closing byte per frame kind
    localparam logic [IdxW-1:0] LastSettings = IdxW'(8);
    localparam logic [IdxW-1:0] LastSwing    = IdxW'(5);

    typedef struct packed {
        logic [FrameBytes-1:0][7:0] bytes;    // byte k goes out k-th
        logic [IdxW-1:0]            last_idx;
    } t_frame;

endpackage

@@ hw/rtl/ccfe_build.sv @@
module ccfe_build (
    input  logic                  i_req_type,
    input  logic [2:0]            i_hvac_mode,
    input  logic signed [10:0]    i_target_tenths,
    input  logic [2:0]            i_fan_speed,
    input  logic                  i_swing_vert,
    input  logic                  i_swing_horiz,
    output ccfe_pkg::t_frame      o_frame
);
    import ccfe_pkg::*;

    logic signed [10:0] temp_cl;
    logic [6:0]         temp_off;
    logic [7:0]         temp_rnd;
    logic [15:0]        temp_prod;
    logic [7:0]         power_b;
    logic [7:0]         mode_b;
    logic [7:0]         temp_b;
    logic [7:0]         fan_b;
    logic [7:0]         swing_b;
    logic [7:0]         set_sum;
    logic [7:0]         swing_sum;

    function automatic logic [7:0] fix_cks(input logic [7:0] s);
        if (s == 8'h02 || s == 8'h03 || s == 8'h06) begin
            return s + 8'd2;
        end
        return s;
    endfunction

    always_comb begin
        // clamp, then round half-degree steps: (d + 2) / 5 as multiply by 205 >> 10
        if (i_target_tenths < TempMin) begin
            temp_cl = TempMin;
        end else if (i_target_tenths > TempMax) begin
            temp_cl = TempMax;
        end else begin
            temp_cl = i_target_tenths;
        end
        temp_off  = 7'(temp_cl - TempMin);
        temp_rnd  = {1'b0, temp_off} + 8'd2;
        temp_prod = 16'(temp_rnd) * 16'd205;
        temp_b    = TempBase + {3'b000, temp_prod[14:10]};

        power_b = (i_hvac_mode == ModeOff) ? PowerOff : PowerOn;

        case (i_hvac_mode)
            ModeDry:  mode_b = WireDry;
            ModeCool: mode_b = WireCool;
            ModeHeat: mode_b = WireHeat;
            ModeFan:  mode_b = WireFan;
            default:  mode_b = WireAuto;
        endcase

        case (i_fan_speed)
            SpeedLow:  fan_b = FanLow;
            SpeedMid:  fan_b = FanMid;
            SpeedHigh: fan_b = FanHigh;
            default:   fan_b = FanAuto;
        endcase

        swing_b   = {6'b0, i_swing_horiz, i_swing_vert};
        set_sum   = (CharF + CmdSet) + (power_b + mode_b) + (temp_b + fan_b);
        swing_sum = CharF + CmdSwing + swing_b;

        o_frame.bytes    = '0;
        o_frame.bytes[0] = StxByte;
        o_frame.bytes[1] = CharF;
        if (i_req_type == ReqSettings) begin
            o_frame.bytes[2] = CmdSet;
            o_frame.bytes[3] = power_b;
            o_frame.bytes[4] = mode_b;
            o_frame.bytes[5] = temp_b;
            o_frame.bytes[6] = fan_b;
            o_frame.bytes[7] = fix_cks(set_sum);
            o_frame.bytes[8] = EtxByte;
            o_frame.last_idx = LastSettings;
        end else begin
            o_frame.bytes[2] = CmdSwing;
            o_frame.bytes[3] = swing_b;
            o_frame.bytes[4] = fix_cks(swing_sum);
            o_frame.bytes[5] = EtxByte;
            o_frame.last_idx = LastSwing;
        end
    end

endmodule

@@ hw/rtl/ccfe_serializer.sv @@
module ccfe_serializer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ccfe_pkg::t_frame      i_frame,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_data,
    output logic                  o_last
);
    import ccfe_pkg::*;

    logic                       r_pend_valid;
    t_frame                     r_pend;
    logic                       r_act_valid;
    logic [FrameBytes-1:0][7:0] r_shift;
    logic [IdxW-1:0]            r_rem;
    logic                       load_act;
    logic                       out_xfer;

    assign o_ready  = !r_pend_valid;
    assign out_xfer = r_act_valid && i_ready;
    assign load_act = r_pend_valid && (!r_act_valid || (out_xfer && r_rem == '0));

    // hold one built frame while the previous one drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_pend_valid <= 1'b1;
        end else if (load_act) begin
            r_pend_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_pend <= i_frame;
        end
    end

    // shift bytes out, lowest first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
            r_rem       <= '0;
        end else if (load_act) begin
            r_act_valid <= 1'b1;
            r_rem       <= r_pend.last_idx;
        end else if (out_xfer) begin
            if (r_rem == '0) begin
                r_act_valid <= 1'b0;
            end else begin
                r_rem <= r_rem - IdxW'(1);
            end
        end
        if (load_act) begin
            r_shift <= r_pend.bytes;
        end else if (out_xfer) begin
            r_shift <= {8'h00, r_shift[FrameBytes-1:1]};
        end
    end

    assign o_valid = r_act_valid;
    assign o_data  = r_shift[0];
    assign o_last  = (r_rem == '0);

    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_rem != '0) |=> r_act_valid)
        else $error("frame broke off before its closing byte");

    a_next_frame_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_rem == '0 && r_pend_valid) |=> (r_act_valid && r_shift[0] == StxByte))
        else $error("queued frame did not follow the closing byte");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_pend_valid)
        else $error("accepted request lost");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_valid |-> (r_rem <= LastSettings))
        else $error("byte count out of range");

endmodule

@@ hw/rtl/climate_command_frame_encoder.sv @@
// Command frame encoder for an air conditioner serial link.
// Slave channel (s_axis): one request per transfer. tuser carries the
// request kind (0 settings, 1 swing); tdata carries the settings and swing
// fields. Master channel (m_axis): one frame byte per transfer, tlast set on
// the closing ETX byte. A settings request gives 9 bytes, a swing request 6.
// Each request is encoded in one pass of short logic at the slave port into
// a one-frame holding register; a shift register then drives the byte out.
// The first byte (STX) is presented once the request has passed from the
// holding register into the output shift register. The master side moves
// one byte per cycle while the receiver is ready, so the output shift
// register sets the pace of requests, with no idle gap between frames when
// the next request is already held.
// Reset clears both valid flags; no byte is presented until a request
// arrives. When the receiver stalls, the current byte holds on the port and
// the holding register takes at most one further request, after which
// s_axis tready stays low until that frame starts to shift out.
module climate_command_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] hvac_mode, [13:3] target_tenths, [16:14] fan_speed,
    // [17] swing_vert, [18] swing_horiz, [23:19] zero
    input  logic [23:0] i_s_axis_tdata,
    // [0] req_type
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] tx_byte
    output logic [7:0]  o_m_axis_tdata,
    // frame_last
    output logic        o_m_axis_tlast
);
    import ccfe_pkg::*;

    t_frame built;

    // encode the request fields straight off the bus
    ccfe_build u_build (
        .i_req_type      (i_s_axis_tuser),
        .i_hvac_mode     (i_s_axis_tdata[2:0]),
        .i_target_tenths (i_s_axis_tdata[13:3]),
        .i_fan_speed     (i_s_axis_tdata[16:14]),
        .i_swing_vert    (i_s_axis_tdata[17]),
        .i_swing_horiz   (i_s_axis_tdata[18]),
        .o_frame         (built)
    );

    // hold the frame, then advance one byte per transfer
    ccfe_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_frame (built),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    import ccfe_pkg::*;

    // Frame lengths and checksum escape
    localparam int         SwingLen    = 6;
    localparam int         SettingsLen = FrameBytes;
    localparam logic [7:0] AckByte     = 8'h06;
    localparam logic [7:0] ChkBump     = 8'd2;

    localparam int RandItems = 78;
    localparam int DrainTail = 20;   // cycles after the last byte, pipeline is two deep
    localparam int MaxShown  = 10;

    typedef struct {
        logic                   kind;
        logic [2:0]             mode;
        logic signed [10:0]     tenths;
        logic [2:0]             fan;
        logic                   vert;
        logic                   horiz;
        logic                   typed;   // frame below is known by hand
        logic [8:0][7:0]        frame;   // byte k at [k]
    } t_cmd_req;

    typedef struct {
        logic [7:0] tx;
        logic       last;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_data;
    logic        m_last;

    t_cmd_req    dir_rows[$];
    t_frame_byte tx_expect_q[$];
    int          err_cnt = 0;
    logic [31:0] cyc = '0;

    climate_command_frame_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("climate_command_frame_encoder: mismatch");
        $finish;
    end

    // Map the 8-bit sum away from the control bytes
    function automatic logic [7:0] fix_sum(input logic [7:0] sum);
        if (sum == StxByte || sum == EtxByte || sum == AckByte) begin
            return sum + ChkBump;
        end
        return sum;
    endfunction

    // Temperature char: clamp to 18..30 C, then nearest half-degree step above '@'
    function automatic logic [7:0] temp_char(input logic signed [10:0] tenths);
        logic signed [10:0] t;
        int                 steps;
        t = tenths;
        if (t < TempMin) t = TempMin;
        if (t > TempMax) t = TempMax;
        steps = (int'(t - TempMin) + 2) / 5;
        return TempBase + 8'(steps);
    endfunction

    // Queue every byte of the frame that one request should produce
    function automatic void encode_frame(input t_cmd_req r);
        logic [8:0][7:0] b;
        logic [7:0]      sum;
        int              n;
        t_frame_byte     fb;
        b = '0;
        b[0] = StxByte;
        b[1] = CharF;
        if (r.typed) begin
            b = r.frame;
            n = (r.kind == ReqSwing) ? SwingLen : SettingsLen;
        end else if (r.kind == ReqSettings) begin
            b[2] = CmdSet;
            b[3] = (r.mode == ModeOff) ? PowerOff : PowerOn;
            case (r.mode)
                ModeDry:  b[4] = WireDry;
                ModeCool: b[4] = WireCool;
                ModeHeat: b[4] = WireHeat;
                ModeFan:  b[4] = WireFan;
                default:  b[4] = WireAuto;
            endcase
            b[5] = temp_char(r.tenths);
            case (r.fan)
                SpeedLow:  b[6] = FanLow;
                SpeedMid:  b[6] = FanMid;
                SpeedHigh: b[6] = FanHigh;
                default:   b[6] = FanAuto;
            endcase
            sum = b[1] + b[2] + b[3] + b[4] + b[5] + b[6];
            b[7] = fix_sum(sum);
            b[8] = EtxByte;
            n = SettingsLen;
        end else begin
            b[2] = CmdSwing;
            b[3] = {6'd0, r.horiz, r.vert};
            b[4] = fix_sum(b[1] + b[2] + b[3]);
            b[5] = EtxByte;
            n = SwingLen;
        end
        for (int k = 0; k < n; k++) begin
            fb.tx   = b[k];
            fb.last = (k == n - 1);
            tx_expect_q.insert(tx_expect_q.size(), fb);
        end
    endfunction

    task automatic add_row(input logic kind, input int mode, input int tenths, input int fan,
                           input logic vert, input logic horiz,
                           input logic typed = 1'b0, input logic [8:0][7:0] frame = '0);
        t_cmd_req r;
        r.kind   = kind;
        r.mode   = 3'(mode);
        r.tenths = 11'(tenths);
        r.fan    = 3'(fan);
        r.vert   = vert;
        r.horiz  = horiz;
        r.typed  = typed;
        r.frame  = frame;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // Mostly realistic temperatures, sometimes the whole 11-bit range
    function automatic t_cmd_req rand_req();
        t_cmd_req r;
        r.kind   = ($urandom_range(0, 2) == 0) ? ReqSwing : ReqSettings;
        r.mode   = 3'($urandom_range(0, 7));
        r.tenths = ($urandom_range(0, 3) != 0) ? 11'($urandom_range(150, 330))
                                               : 11'($urandom_range(0, 2047));
        r.fan    = 3'($urandom_range(0, 7));
        r.vert   = 1'($urandom_range(0, 1));
        r.horiz  = 1'($urandom_range(0, 1));
        r.typed  = 1'b0;
        r.frame  = '0;
        return r;
    endfunction

    task automatic note_error(input string what, input logic [7:0] want, input logic [7:0] got);
        if (err_cnt < MaxShown) begin
            $display("%0t: %s expected %h got %h", $realtime, what, want, got);
        end
        err_cnt++;
    endtask

    // Receiver: rotate through always-ready, a fixed stall pattern,
    // coin-flip stalls and long stalls
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        case (cyc[8:7])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'(16'b1011_0111_0010_1101 >> cyc[3:0]);
            2'd2: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Check every byte transfer against the oldest pending expectation
    always @(posedge i_clk) begin : tx_check
        t_frame_byte want;
        if (rst_n && m_valid && m_ready) begin
            if (tx_expect_q.size() == 0) begin
                note_error("unexpected tx_byte", 8'h00, m_data);
            end else begin
                want = tx_expect_q.pop_front();
                if (m_data !== want.tx) note_error("tx_byte", want.tx, m_data);
                if (m_last !== want.last) note_error("frame_last", 8'(want.last), 8'(m_last));
            end
        end
    end

    initial begin : sender
        t_cmd_req r;
        int       total;
        int       burst_left;
        logic     drain;
        // kind, mode, tenths, fan, vert, horiz [, typed frame]
        add_row(ReqSettings, 0, -200, 0, 0, 0, 1'b1,
                {8'h03, 8'h28, 8'h41, 8'h40, 8'h00, 8'h30, 8'h31, 8'h46, 8'h02});
        add_row(ReqSettings, 4, 600, 3, 0, 0, 1'b1,
                {8'h03, 8'h39, 8'h35, 8'h58, 8'h04, 8'h31, 8'h31, 8'h46, 8'h02});
        add_row(ReqSwing, 0, 0, 0, 0, 0, 1'b1,
                {8'h00, 8'h00, 8'h00, 8'h03, 8'h7B, 8'h00, 8'h35, 8'h46, 8'h02});
        add_row(ReqSwing, 0, 0, 0, 1, 1, 1'b1,
                {8'h00, 8'h00, 8'h00, 8'h03, 8'h7E, 8'h03, 8'h35, 8'h46, 8'h02});
        add_row(ReqSettings, 1, 180, 1, 0, 0);
        add_row(ReqSettings, 2, 181, 2, 0, 0);
        add_row(ReqSettings, 3, 182, 4, 0, 0);
        add_row(ReqSettings, 5, 183, 5, 0, 0);
        add_row(ReqSettings, 6, 184, 6, 0, 0);
        add_row(ReqSettings, 7, 185, 7, 0, 0);       // unused mode code, fan out of range
        add_row(ReqSettings, 0, 187, 0, 1, 1);       // swing bits ignored
        add_row(ReqSettings, 3, 300, 3, 0, 0);
        add_row(ReqSettings, 4, 301, 1, 0, 0);       // just above the ceiling
        add_row(ReqSettings, 1, 179, 2, 0, 0);       // just below the floor
        add_row(ReqSettings, 2, 1023, 3, 0, 0);
        add_row(ReqSettings, 5, -1024, 0, 0, 0);
        add_row(ReqSettings, 6, -1, 1, 1, 0);
        add_row(ReqSettings, 3, 242, 2, 0, 1);       // rounds down
        add_row(ReqSettings, 3, 243, 2, 0, 0);       // rounds up
        add_row(ReqSwing, 7, 1023, 7, 1, 0);         // settings fields ignored
        add_row(ReqSwing, 5, -1024, 3, 0, 1);
        add_row(ReqSettings, 6, 250, 3, 1, 0);

        total = dir_rows.size() + RandItems;
        burst_left = 0;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (int idx = 0; idx < total; idx++) begin
            r = (idx < dir_rows.size()) ? dir_rows[idx] : rand_req();
            s_data  <= {5'd0, r.horiz, r.vert, r.fan, r.tenths, r.mode};
            s_user  <= r.kind;
            s_valid <= 1'b1;
            // hold until the transfer happens
            @(posedge i_clk);
            while (!s_ready) @(posedge i_clk);
            encode_frame(r);

            // drain fully once after the directed rows and once mid-way
            drain = (idx == dir_rows.size() - 1) || (idx == dir_rows.size() + RandItems / 2);
            if (burst_left > 0 && !drain) begin
                burst_left--;
            end else if (idx < total - 1) begin
                s_valid <= 1'b0;
                if (drain) begin
                    do @(posedge i_clk); while (tx_expect_q.size() != 0);
                end else begin
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(0, 7);
            end
        end

        s_valid <= 1'b0;
        do @(posedge i_clk); while (tx_expect_q.size() != 0);
        repeat (DrainTail) @(posedge i_clk);

        if (err_cnt == 0 && tx_expect_q.size() == 0) begin
            $display("climate_command_frame_encoder: match");
        end else begin
            $display("climate_command_frame_encoder: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ccfe_pkg.sv
hw/rtl/ccfe_build.sv
hw/rtl/ccfe_serializer.sv
hw/rtl/climate_command_frame_encoder.sv
dv/tb_top.sv
